FILE: rtl/mwsf_pkg.sv
`timescale 1ns / 1ps
package mwsf_pkg;

  localparam int CFG_W  = 31;  // configuration register width
  localparam int POS_W  = 32;  // position and force width
  localparam int DIFF_W = 33;  // magnitude of a coordinate difference
  localparam int SQ_W   = 66;  // squared distance
  localparam int RAD_W  = 68;  // squared distance padded to whole bit pairs
  localparam int ROOT_W = 34;  // distance
  localparam int REM_W  = 36;  // square root partial remainder
  localparam int Q_W    = 17;  // direction and mass share, up to 1.0 in Q1.16
  localparam int MAG_W  = 48;  // force magnitudes before saturation
  localparam int FRAC   = 16;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_REST  = 2'd0;
  localparam logic [IDX_W-1:0] REG_STIFF = 2'd1;
  localparam logic [IDX_W-1:0] REG_MASS1 = 2'd2;
  localparam logic [IDX_W-1:0] REG_MASS2 = 2'd3;

  localparam logic [CFG_W-1:0] CFG_RESET = 31'd65536;
  localparam logic [Q_W-1:0]   Q_ONE     = 17'd65536;

  // Stage map of the pipeline
  localparam int ST_IN   = 0;
  localparam int ST_SQ   = 1;
  localparam int ST_SUM  = 2;
  localparam int ST_RT0  = 3;
  localparam int RT_N    = ROOT_W;
  localparam int ST_DV0  = ST_RT0 + RT_N;
  localparam int DV_N    = Q_W;
  localparam int ST_M0   = ST_DV0 + DV_N;
  localparam int ST_M1   = ST_M0 + 1;
  localparam int ST_OUT  = ST_M1 + 1;
  localparam int N_STG   = ST_OUT + 1;

  typedef struct packed {
    logic                dxn;
    logic                dyn;
    logic                pin1;
    logic                pin2;
    logic [DIFF_W-1:0]   adx;
    logic [DIFF_W-1:0]   ady;
    logic [SQ_W-1:0]     sqx;
    logic [SQ_W-1:0]     sqy;
    logic [SQ_W-1:0]     rad;
    logic [REM_W-1:0]    rem;
    logic [ROOT_W-1:0]   root;
    logic                ern;
    logic [ROOT_W-1:0]   erm;
    logic [MAG_W-1:0]    amag;
    logic [ROOT_W-1:0]   xr;
    logic [ROOT_W-1:0]   yr;
    logic [Q_W-1:0]      xq;
    logic [Q_W-1:0]      yq;
    logic [POS_W-1:0]    sr;
    logic [Q_W-1:0]      sq;
    logic [MAG_W-1:0]    mx;
    logic [MAG_W-1:0]    my;
    logic [Q_W-1:0]      sh1;
    logic [Q_W-1:0]      sh2;
    logic [MAG_W-1:0]    c1x;
    logic [MAG_W-1:0]    c1y;
    logic [MAG_W-1:0]    c2x;
    logic [MAG_W-1:0]    c2y;
    logic [POS_W-1:0]    f1x;
    logic [POS_W-1:0]    f1y;
    logic [POS_W-1:0]    f2x;
    logic [POS_W-1:0]    f2y;
    logic                applied;
  } pipe_t;

  // Apply sign and clamp to the signed 32-bit range
  function automatic logic [POS_W-1:0] sat_signed(input logic neg,
                                                   input logic [MAG_W-1:0] mag);
    logic [POS_W-1:0] r;
    if (neg) begin
      if (mag > MAG_W'(64'h8000_0000)) begin
        r = 32'h8000_0000;
      end else begin
        r = ~mag[POS_W-1:0] + 32'd1;
      end
    end else begin
      if (mag > MAG_W'(64'h7FFF_FFFF)) begin
        r = 32'h7FFF_FFFF;
      end else begin
        r = mag[POS_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/mass_weighted_spring_force_unit.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle while the output is not stalled; 34 square root
// stages (one root bit each) and 17 divider stages (one quotient bit each) set the depth.
// A stall on the output freezes the whole pipeline; nothing is dropped.
// Reset (synchronous, active high) empties the pipeline and sets all four
// registers to 1.0.
module mass_weighted_spring_force_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // first_x, first_y, second_x, second_y
  input  logic [1:0]   s_axis_tuser,   // first_pinned, second_pinned
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // force_first_x, force_first_y,
                                       // force_second_x, force_second_y
  output logic [0:0]   m_axis_tuser,   // applied
  input  logic         cfg_we,
  input  logic [mwsf_pkg::IDX_W-1:0] cfg_index,
  input  logic [mwsf_pkg::CFG_W-1:0] cfg_data
);

  localparam int NS = mwsf_pkg::N_STG;

  logic [mwsf_pkg::CFG_W-1:0] rest_length;
  logic [mwsf_pkg::CFG_W-1:0] stiffness;
  logic [mwsf_pkg::CFG_W-1:0] mass_first;
  logic [mwsf_pkg::CFG_W-1:0] mass_second;
  logic [mwsf_pkg::POS_W-1:0] msum;

  mwsf_pkg::pipe_t st [NS];
  logic [NS-1:0]   vld;
  logic            adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_length <= mwsf_pkg::CFG_RESET;
      stiffness   <= mwsf_pkg::CFG_RESET;
      mass_first  <= mwsf_pkg::CFG_RESET;
      mass_second <= mwsf_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mwsf_pkg::REG_REST:  rest_length <= cfg_data;
        mwsf_pkg::REG_STIFF: stiffness   <= cfg_data;
        mwsf_pkg::REG_MASS1: mass_first  <= cfg_data;
        mwsf_pkg::REG_MASS2: mass_second <= cfg_data;
        default: ;
      endcase
    end
  end

  assign msum = {1'b0, mass_first} + {1'b0, mass_second};

  // Global advance: the pipeline moves unless the output is full and stalled
  assign adv           = !vld[NS-1] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], s_axis_tvalid};
    end
  end

  genvar g;
  generate
    for (g = 0; g < NS; g++) begin : g_stg
      mwsf_pkg::pipe_t nxt;

      if (g == mwsf_pkg::ST_IN) begin : g_in
        logic signed [mwsf_pkg::DIFF_W-1:0] dx;
        logic signed [mwsf_pkg::DIFF_W-1:0] dy;
        always_comb begin
          dx = {s_axis_tdata[95], s_axis_tdata[95:64]} - {s_axis_tdata[31], s_axis_tdata[31:0]};
          dy = {s_axis_tdata[127], s_axis_tdata[127:96]}
             - {s_axis_tdata[63], s_axis_tdata[63:32]};
          nxt      = '0;
          nxt.dxn  = dx[mwsf_pkg::DIFF_W-1];
          nxt.dyn  = dy[mwsf_pkg::DIFF_W-1];
          nxt.adx  = dx[mwsf_pkg::DIFF_W-1] ? -dx : dx;
          nxt.ady  = dy[mwsf_pkg::DIFF_W-1] ? -dy : dy;
          nxt.pin1 = s_axis_tuser[0];
          nxt.pin2 = s_axis_tuser[1];
        end
      end else if (g == mwsf_pkg::ST_SQ) begin : g_sq
        always_comb begin
          nxt     = st[g-1];
          nxt.sqx = mwsf_pkg::SQ_W'(st[g-1].adx) * mwsf_pkg::SQ_W'(st[g-1].adx);
          nxt.sqy = mwsf_pkg::SQ_W'(st[g-1].ady) * mwsf_pkg::SQ_W'(st[g-1].ady);
        end
      end else if (g == mwsf_pkg::ST_SUM) begin : g_sum
        always_comb begin
          nxt     = st[g-1];
          nxt.rad = st[g-1].sqx + st[g-1].sqy;
        end
      end else if (g < mwsf_pkg::ST_DV0) begin : g_rt
        // One root bit per stage, top bit pair first
        localparam int RI = g - mwsf_pkg::ST_RT0;
        logic [mwsf_pkg::RAD_W-1:0]  padded;
        logic [mwsf_pkg::REM_W-1:0]  rem_p;
        logic [mwsf_pkg::ROOT_W-1:0] root_p;
        logic [mwsf_pkg::REM_W+1:0]  rt;
        logic [mwsf_pkg::REM_W+1:0]  trial;
        always_comb begin
          nxt    = st[g-1];
          padded = {2'b00, st[g-1].rad};
          rem_p  = (RI == 0) ? '0 : st[g-1].rem;
          root_p = (RI == 0) ? '0 : st[g-1].root;
          rt     = {rem_p, padded[mwsf_pkg::RAD_W-1-2*RI -: 2]};
          trial  = {2'b00, root_p, 2'b01};
          if (rt >= trial) begin
            nxt.rem  = mwsf_pkg::REM_W'(rt - trial);
            nxt.root = {root_p[mwsf_pkg::ROOT_W-2:0], 1'b1};
          end else begin
            nxt.rem  = rt[mwsf_pkg::REM_W-1:0];
            nxt.root = {root_p[mwsf_pkg::ROOT_W-2:0], 1'b0};
          end
        end
      end else if (g < mwsf_pkg::ST_M0) begin : g_dv
        // One quotient bit per stage for both direction components and the mass share
        localparam int DJ = g - mwsf_pkg::ST_DV0;
        logic [mwsf_pkg::ROOT_W-1:0] xp;
        logic [mwsf_pkg::ROOT_W-1:0] yp;
        logic [mwsf_pkg::POS_W-1:0]  sp;
        logic [mwsf_pkg::ROOT_W:0]   xt;
        logic [mwsf_pkg::ROOT_W:0]   yt;
        logic [mwsf_pkg::POS_W:0]    stt;
        logic [mwsf_pkg::ROOT_W:0]   dv;
        logic [mwsf_pkg::POS_W:0]    sv;
        logic [64:0]                 aprod;
        always_comb begin
          nxt = st[g-1];
          dv  = {1'b0, st[g-1].root};
          sv  = {1'b0, msum};
          xp  = (DJ == 0) ? {2'b00, st[g-1].adx[mwsf_pkg::DIFF_W-1:1]} : st[g-1].xr;
          yp  = (DJ == 0) ? {2'b00, st[g-1].ady[mwsf_pkg::DIFF_W-1:1]} : st[g-1].yr;
          sp  = (DJ == 0) ? {2'b00, mass_second[mwsf_pkg::CFG_W-1:1]} : st[g-1].sr;
          xt  = {xp, (DJ == 0) ? st[g-1].adx[0] : 1'b0};
          yt  = {yp, (DJ == 0) ? st[g-1].ady[0] : 1'b0};
          stt = {sp, (DJ == 0) ? mass_second[0] : 1'b0};
          if (xt >= dv) begin
            nxt.xr = mwsf_pkg::ROOT_W'(xt - dv);
            nxt.xq = {st[g-1].xq[mwsf_pkg::Q_W-2:0], 1'b1};
          end else begin
            nxt.xr = xt[mwsf_pkg::ROOT_W-1:0];
            nxt.xq = {st[g-1].xq[mwsf_pkg::Q_W-2:0], 1'b0};
          end
          if (yt >= dv) begin
            nxt.yr = mwsf_pkg::ROOT_W'(yt - dv);
            nxt.yq = {st[g-1].yq[mwsf_pkg::Q_W-2:0], 1'b1};
          end else begin
            nxt.yr = yt[mwsf_pkg::ROOT_W-1:0];
            nxt.yq = {st[g-1].yq[mwsf_pkg::Q_W-2:0], 1'b0};
          end
          if (stt >= sv) begin
            nxt.sr = mwsf_pkg::POS_W'(stt - sv);
            nxt.sq = {st[g-1].sq[mwsf_pkg::Q_W-2:0], 1'b1};
          end else begin
            nxt.sr = stt[mwsf_pkg::POS_W-1:0];
            nxt.sq = {st[g-1].sq[mwsf_pkg::Q_W-2:0], 1'b0};
          end
          aprod = '0;
          if (DJ == 0) begin
            if (st[g-1].root >= mwsf_pkg::ROOT_W'(rest_length)) begin
              nxt.ern = 1'b0;
              nxt.erm = st[g-1].root - mwsf_pkg::ROOT_W'(rest_length);
            end else begin
              nxt.ern = 1'b1;
              nxt.erm = mwsf_pkg::ROOT_W'(rest_length) - st[g-1].root;
            end
          end
          if (DJ == 1) begin
            aprod    = 65'(st[g-1].erm) * 65'(stiffness);
            nxt.amag = aprod[63:16];
          end
        end
      end else if (g == mwsf_pkg::ST_M0) begin : g_m0
        logic [mwsf_pkg::Q_W-1:0] qx;
        logic [mwsf_pkg::Q_W-1:0] qy;
        logic [64:0]              px;
        logic [64:0]              py;
        always_comb begin
          nxt = st[g-1];
          qx  = (st[g-1].root == '0) ? '0 : st[g-1].xq;
          qy  = (st[g-1].root == '0) ? '0 : st[g-1].yq;
          px  = 65'(st[g-1].amag) * 65'(qx);
          py  = 65'(st[g-1].amag) * 65'(qy);
          nxt.mx = px[63:16];
          nxt.my = py[63:16];
          // The second share is one minus the ceiling of the first
          if (msum == '0) begin
            nxt.sh1 = '0;
            nxt.sh2 = '0;
          end else begin
            nxt.sh1 = st[g-1].sq;
            nxt.sh2 = mwsf_pkg::Q_ONE - st[g-1].sq
                    - mwsf_pkg::Q_W'(st[g-1].sr != '0);
          end
        end
      end else if (g == mwsf_pkg::ST_M1) begin : g_m1
        logic [64:0] p1x;
        logic [64:0] p1y;
        logic [64:0] p2x;
        logic [64:0] p2y;
        always_comb begin
          nxt = st[g-1];
          p1x = 65'(st[g-1].mx) * 65'(st[g-1].sh1);
          p1y = 65'(st[g-1].my) * 65'(st[g-1].sh1);
          p2x = 65'(st[g-1].mx) * 65'(st[g-1].sh2);
          p2y = 65'(st[g-1].my) * 65'(st[g-1].sh2);
          nxt.c1x = p1x[63:16];
          nxt.c1y = p1y[63:16];
          nxt.c2x = p2x[63:16];
          nxt.c2y = p2y[63:16];
        end
      end else begin : g_out
        logic                       free2;
        logic [mwsf_pkg::MAG_W-1:0] m1x;
        logic [mwsf_pkg::MAG_W-1:0] m1y;
        logic [mwsf_pkg::MAG_W-1:0] m2x;
        logic [mwsf_pkg::MAG_W-1:0] m2y;
        always_comb begin
          nxt   = st[g-1];
          free2 = !st[g-1].pin1 && !st[g-1].pin2;
          m1x   = free2 ? st[g-1].c1x : st[g-1].mx;
          m1y   = free2 ? st[g-1].c1y : st[g-1].my;
          m2x   = free2 ? st[g-1].c2x : st[g-1].mx;
          m2y   = free2 ? st[g-1].c2y : st[g-1].my;
          nxt.f1x = '0;
          nxt.f1y = '0;
          nxt.f2x = '0;
          nxt.f2y = '0;
          if (!st[g-1].pin1) begin
            nxt.f1x = mwsf_pkg::sat_signed((st[g-1].ern != st[g-1].dxn) && m1x != '0, m1x);
            nxt.f1y = mwsf_pkg::sat_signed((st[g-1].ern != st[g-1].dyn) && m1y != '0, m1y);
          end
          // The second point pulls the opposite way
          if (!st[g-1].pin2) begin
            nxt.f2x = mwsf_pkg::sat_signed((st[g-1].ern == st[g-1].dxn) && m2x != '0, m2x);
            nxt.f2y = mwsf_pkg::sat_signed((st[g-1].ern == st[g-1].dyn) && m2y != '0, m2y);
          end
          nxt.applied = !(st[g-1].pin1 && st[g-1].pin2);
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          st[g] <= nxt;
        end
      end
    end
  endgenerate

  assign m_axis_tvalid = vld[NS-1];
  assign m_axis_tdata  = {st[NS-1].f2y, st[NS-1].f2x, st[NS-1].f1y, st[NS-1].f1x};
  assign m_axis_tuser  = st[NS-1].applied;

  localparam int LAST_RT = mwsf_pkg::ST_DV0 - 1;

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_no_force: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("force given with both ends pinned");

  a_root: assert property (@(posedge clk) disable iff (rst)
    vld[LAST_RT] |->
      (68'(st[LAST_RT].root) * 68'(st[LAST_RT].root) <= 68'(st[LAST_RT].rad)) &&
      ((68'(st[LAST_RT].root) + 68'd1) * (68'(st[LAST_RT].root) + 68'd1)
        > 68'(st[LAST_RT].rad)))
    else $error("square root out of range");

  a_share: assert property (@(posedge clk) disable iff (rst)
    vld[mwsf_pkg::ST_M0] |->
      18'(st[mwsf_pkg::ST_M0].sh1) + 18'(st[mwsf_pkg::ST_M0].sh2) <= 18'd65536)
    else $error("mass shares exceed one");

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic [31:0] f1x;
    logic [31:0] f1y;
    logic [31:0] f2x;
    logic [31:0] f2y;
    logic        applied;
  } spring_force_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;   // first_x, first_y, second_x, second_y
  logic [1:0]   s_axis_tuser;   // first_pinned, second_pinned
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;   // force_first_x, force_first_y, force_second_x, force_second_y
  logic [0:0]   m_axis_tuser;   // applied
  logic         cfg_we;
  logic [mwsf_pkg::IDX_W-1:0] cfg_index;
  logic [mwsf_pkg::CFG_W-1:0] cfg_data;

  logic [63:0] rest_len_q, stiff_q, mass1_q, mass2_q;
  spring_force_t force_q[$];
  int  errors;
  bit  idle_on;
  int  hold_cycles;

  mass_weighted_spring_force_unit u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic logic [31:0] clamp_force(logic neg, logic [63:0] mag);
    logic [31:0] r;
    if (neg) begin
      if (mag > 64'h8000_0000) r = 32'h8000_0000;
      else r = 32'(64'h1_0000_0000 - mag);
    end else begin
      if (mag > 64'h7FFF_FFFF) r = 32'h7FFF_FFFF;
      else r = mag[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] force_axis(logic [63:0] a, logic err_neg, longint u,
                                             logic use_share, logic [63:0] share);
    logic        u_neg;
    logic [63:0] um, m;
    u_neg = u < 0;
    um = u_neg ? 64'(-u) : 64'(u);
    m = (a * um) >> 16;
    if (use_share) m = (m * share) >> 16;
    return clamp_force(err_neg != u_neg && m != 0, m);
  endfunction

  function automatic spring_force_t spring_forces(logic [127:0] pos, logic [1:0] pins);
    spring_force_t r;
    longint      dx, dy, ux, uy, err;
    logic [63:0] adx, ady, span, c, a, sum, share1, share2;
    logic [127:0] rad;
    logic        err_neg, both_free;
    r = '0;
    if (pins == 2'b11) return r;
    r.applied = 1'b1;
    dx = longint'($signed(pos[95:64])) - longint'($signed(pos[31:0]));
    dy = longint'($signed(pos[127:96])) - longint'($signed(pos[63:32]));
    adx = dx < 0 ? 64'(-dx) : 64'(dx);
    ady = dy < 0 ? 64'(-dy) : 64'(dy);
    rad = {64'd0, adx} * {64'd0, adx} + {64'd0, ady} * {64'd0, ady};
    span = 0;
    for (int b = 33; b >= 0; b--) begin
      c = span | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= rad) span = c;
    end
    ux = 0;
    uy = 0;
    if (span != 0) begin
      ux = longint'((adx << 16) / span);
      uy = longint'((ady << 16) / span);
      if (dx < 0) ux = -ux;
      if (dy < 0) uy = -uy;
    end
    err = longint'(span) - longint'(rest_len_q);
    err_neg = err < 0;
    a = ((err_neg ? 64'(-err) : 64'(err)) * stiff_q) >> 16;
    sum = mass1_q + mass2_q;
    share1 = 0;
    share2 = 0;
    if (sum != 0) begin
      share1 = (mass2_q << 16) / sum;
      share2 = (mass1_q << 16) / sum;
    end
    both_free = pins == 2'b00;
    if (!pins[0]) begin
      r.f1x = force_axis(a, err_neg, ux, both_free, share1);
      r.f1y = force_axis(a, err_neg, uy, both_free, share1);
    end
    if (!pins[1]) begin
      r.f2x = force_axis(a, err_neg, -ux, both_free, share2);
      r.f2y = force_axis(a, err_neg, -uy, both_free, share2);
    end
    return r;
  endfunction

  // Predict on every accepted request; check every accepted result
  always @(posedge clk) begin
    spring_force_t exp_f;
    if (!rst && s_axis_tvalid && s_axis_tready)
      force_q.push_back(spring_forces(s_axis_tdata, s_axis_tuser));
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (force_q.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        errors++;
      end else begin
        exp_f = force_q.pop_front();
        if (m_axis_tdata[31:0] !== exp_f.f1x) begin
          $error("force_first_x exp %h got %h", exp_f.f1x, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[63:32] !== exp_f.f1y) begin
          $error("force_first_y exp %h got %h", exp_f.f1y, m_axis_tdata[63:32]);
          errors++;
        end
        if (m_axis_tdata[95:64] !== exp_f.f2x) begin
          $error("force_second_x exp %h got %h", exp_f.f2x, m_axis_tdata[95:64]);
          errors++;
        end
        if (m_axis_tdata[127:96] !== exp_f.f2y) begin
          $error("force_second_y exp %h got %h", exp_f.f2y, m_axis_tdata[127:96]);
          errors++;
        end
        if (m_axis_tuser[0] !== exp_f.applied) begin
          $error("applied exp %b got %b", exp_f.applied, m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus a counted hold-off on request
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready <= !(idle_on && $urandom_range(99) < 9);
    end
  end

  task automatic send_req(logic [31:0] fx, logic [31:0] fy, logic [31:0] sx,
                          logic [31:0] sy, logic [1:0] pins);
    if (idle_on && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sy, sx, fy, fx};
    s_axis_tuser  <= pins;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (force_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(logic [mwsf_pkg::IDX_W-1:0] idx, logic [mwsf_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mwsf_pkg::REG_REST:  rest_len_q = 64'(val);
      mwsf_pkg::REG_STIFF: stiff_q    = 64'(val);
      mwsf_pkg::REG_MASS1: mass1_q    = 64'(val);
      default:             mass2_q    = 64'(val);
    endcase
  endtask

  task automatic set_spring(logic [30:0] rl, logic [30:0] k, logic [30:0] m1, logic [30:0] m2);
    drain();
    write_reg(mwsf_pkg::REG_REST, rl);
    write_reg(mwsf_pkg::REG_STIFF, k);
    write_reg(mwsf_pkg::REG_MASS1, m1);
    write_reg(mwsf_pkg::REG_MASS2, m2);
  endtask

  task automatic send_random(int n);
    logic [31:0] fx, fy, sx, sy;
    for (int i = 0; i < n; i++) begin
      fx = $urandom;
      fy = $urandom;
      if ($urandom_range(3) == 0) begin
        sx = $urandom;
        sy = $urandom;
      end else begin
        // nearby points keep the stretch small and realistic
        sx = fx + 32'($signed($urandom_range(2 * 20 * 65536) - 20 * 65536));
        sy = fy + 32'($signed($urandom_range(2 * 20 * 65536) - 20 * 65536));
      end
      send_req(fx, fy, sx, sy, 2'($urandom_range(3)));
    end
  endtask

  task automatic test_directed();
    logic [31:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7FFF_FFFF;
    for (int p = 0; p < 4; p++) begin
      send_req(0, 0, 0, 0, 2'(p));                       // zero distance
      send_req(mn, mn, mx, mx, 2'(p));
      send_req(mx, mx, mn, mn, 2'(p));
      send_req(mn, mx, mx, mn, 2'(p));
      send_req(0, 0, 32'h0003_0000, 32'h0004_0000, 2'(p));
    end
    send_req(32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 2'b00);
  endtask

  task automatic test_settings();
    set_spring(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF);
    test_directed();
    send_random(100);
    set_spring(31'd0, 31'd0, 31'h7FFF_FFFF, 31'd1);
    send_random(60);
    set_spring(31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_random(100);
    set_spring(31'($urandom_range(10 * 65536)), 31'($urandom_range(200 * 65536)),
               31'($urandom_range(1, 5 * 65536)), 31'($urandom_range(1, 5 * 65536)));
    send_random(150);
  endtask

  task automatic test_backpressure();
    drain();
    hold_cycles = 300;
    send_random(120);
  endtask

  task automatic test_pause();
    send_random(40);
    drain();
    send_random(40);
  endtask

  task automatic test_steady();
    idle_on = 1'b0;
    send_random(150);
    idle_on = 1'b1;
    send_random(150);
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = mwsf_pkg::REG_REST;
    cfg_data = '0;
    errors = 0;
    idle_on = 1'b1;
    hold_cycles = 0;
    rest_len_q = 65536;
    stiff_q = 65536;
    mass1_q = 65536;
    mass2_q = 65536;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_settings();
    test_backpressure();
    test_pause();
    test_steady();
    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
